@@ src/fifo_replacement_tracker_core_macros.svh @@
// assertion macros shared by the tracker rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef FIFO_REPLACEMENT_TRACKER_CORE_MACROS_SVH
`define FIFO_REPLACEMENT_TRACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frt assertion failed");

// next-cycle implication
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frt assertion failed");

`else

`define FRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/frt_pkg.sv @@
// shared types and constants of the fifo replacement tracker
// no dependencies
package frt_pkg;

	localparam int ID_BITS   = 16;
	localparam int TIME_BITS = 32;
	localparam int CFG_BITS  = 8;

	localparam logic [CFG_BITS-1:0]  CFG_RESET = 8'd1;
	localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

	// command codes
	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_ACCESS  = 1'b1;

	typedef struct packed {
		logic               command;
		logic [ID_BITS-1:0] item_id;
	} frt_req_t;

	typedef struct packed {
		logic                 hit;
		logic                 evicted;
		logic [ID_BITS-1:0]   evicted_id;
		logic [TIME_BITS-1:0] event_time;
	} frt_rsp_t;

	// control broadcast to every cell
	typedef struct packed {
		logic restart;
		logic shift;
	} frt_cell_ctrl_t;

endpackage

@@ src/frt_cell.sv @@
// one slot of the replacement chain: holds an identifier and compares it
// depends on frt_pkg
module frt_cell import frt_pkg::*; #(
	parameter int IDX      = 0,
	parameter int ID_WIDTH = 16,
	parameter int CW       = 8
) (
	input  logic                clk,
	input  frt_cell_ctrl_t      ctrl,
	input  logic [CW-1:0]       count,
	input  logic [CW-1:0]       load_count,
	input  logic [ID_WIDTH-1:0] key,
	input  logic [ID_WIDTH-1:0] nbr_id,
	output logic [ID_WIDTH-1:0] id,
	output logic                match
);

	localparam logic [CW-1:0]       IDX_C    = CW'(IDX);
	localparam logic [ID_WIDTH-1:0] IDX_ID   = ID_WIDTH'(IDX);

	logic [ID_WIDTH-1:0] id_q;
	logic                active;
	logic                tail;

	// position relative to the live part of the chain
	assign active = IDX_C < count;
	assign tail   = (IDX_C + CW'(1)) == count;

	// compare against the probe identifier
	assign match = active && (id_q == key);
	assign id    = id_q;

	// load on restart, move one place toward the head on replacement
	always_ff @(posedge clk) begin
		if (ctrl.restart) begin
			id_q <= ID_WIDTH'(load_count) - IDX_ID;
		end else if (ctrl.shift) begin
			id_q <= tail ? key : nbr_id;
		end
	end

endmodule

@@ src/frt_out_buf.sv @@
// two-entry result buffer that decouples the core from the consumer
// depends on frt_pkg
module frt_out_buf import frt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  frt_rsp_t push_data,
	output logic     can_push,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output frt_rsp_t rsp
);

	logic [1:0] cnt_q;
	frt_rsp_t   head_q;
	frt_rsp_t   tail_q;
	logic       pop;

	assign pop       = rsp_valid && rsp_ready;
	assign rsp_valid = cnt_q != 2'd0;
	assign rsp       = head_q;
	assign can_push  = cnt_q != 2'd2;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// entry storage, head is the oldest result
	always_ff @(posedge clk) begin
		if (pop && push) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
				tail_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end
	end

endmodule

@@ src/fifo_replacement_tracker_core.sv @@
// fifo replacement tracker: the result of each accepted request is registered in the result buffer
// throughput one request per cycle while the result buffer has room; all slots compare in parallel
// and the chain shifts by one cell on a miss in a non-empty set, so the next request sees the update immediately
// a two-entry result buffer keeps requests flowing while a result waits
// arst_n clears control state: empty set, clock zero, register value 1
`include "fifo_replacement_tracker_core_macros.svh"
module fifo_replacement_tracker_core import frt_pkg::*; #(
	parameter int CAPACITY = 128,
	parameter int ID_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  frt_req_t            req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output frt_rsp_t            rsp,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CFG_BITS-1:0]  cfg_q;
	logic [CW-1:0]        count_q;
	logic [TIME_BITS-1:0] clock_q;

	logic                 acc;
	logic                 restart;
	logic                 access;
	logic [CW-1:0]        load_count;
	logic [ID_WIDTH-1:0]  key;
	logic [CAPACITY-1:0]  match;
	logic [ID_WIDTH-1:0]  ids [CAPACITY];
	logic                 hit;
	logic                 shift;
	logic [TIME_BITS-1:0] clock_next;
	frt_cell_ctrl_t       ctrl;
	frt_rsp_t             res;
	logic                 can_push;

	assign req_ready = can_push;
	assign acc       = req_valid && req_ready;
	assign restart   = acc && (req.command == CMD_RESTART);
	assign access    = acc && (req.command == CMD_ACCESS);
	assign key       = ID_WIDTH'(req.item_id);

	// set size saturated to the chain length
	always_comb begin
		if (32'(cfg_q) > 32'(CAPACITY)) begin
			load_count = CW'(CAPACITY);
		end else begin
			load_count = CW'(cfg_q);
		end
	end

	// membership and replacement decision
	assign hit   = |match;
	assign shift = access && !hit && (count_q != '0);
	assign ctrl  = '{restart: restart, shift: shift};

	// chain of slots, head cell holds the oldest identifier
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ID_WIDTH-1:0] nbr;
		if (i == CAPACITY - 1) begin : g_last
			assign nbr = key;
		end else begin : g_mid
			assign nbr = ids[i+1];
		end
		frt_cell #(
			.IDX      (i),
			.ID_WIDTH (ID_WIDTH),
			.CW       (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.load_count (load_count),
			.key        (key),
			.nbr_id     (nbr),
			.id         (ids[i]),
			.match      (match[i])
		);
	end

	// saturating access clock
	assign clock_next = (clock_q == TIME_MAX) ? clock_q : clock_q + TIME_BITS'(1);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= CFG_RESET;
			count_q <= '0;
			clock_q <= '0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (restart) begin
				count_q <= load_count;
				clock_q <= '0;
			end else if (access) begin
				clock_q <= clock_next;
			end
		end
	end

	// result formation
	always_comb begin
		res = '0;
		if (access) begin
			res.hit        = hit;
			res.evicted    = shift;
			res.evicted_id = shift ? ID_BITS'(ids[0]) : '0;
			res.event_time = clock_next;
		end
	end

	frt_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.can_push  (can_push),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`FRT_ASSERT_NEXT(a_restart_clears_clock, clk, arst_n, restart, clock_q == '0)
	`FRT_ASSERT_NEXT(a_clock_saturates, clk, arst_n, access && (clock_q == TIME_MAX), clock_q == TIME_MAX)
	`FRT_ASSERT_NOW(a_no_evict_on_hit, clk, arst_n, acc, !(res.hit && res.evicted))
	`FRT_ASSERT_NEXT(a_count_stable_on_access, clk, arst_n, access, $stable(count_q))

endmodule

@@ tb/sv/tb_fifo_replacement_tracker_core.sv @@
// self-checking testbench for fifo_replacement_tracker_core
// depends on frt_pkg and the core rtl; a shadow of the fifo set predicts every result not fixed by a directed row
`timescale 1ns / 100ps
module tb_fifo_replacement_tracker_core import frt_pkg::*;;

	localparam int CAPACITY   = 128;
	localparam int ID_WIDTH   = 16;
	localparam int RAND_ITEMS = 1100;

	// directed rows either carry a typed-in result or defer to the shadow set
	localparam logic FIXED   = 1'b1;
	localparam logic PREDICT = 1'b0;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [CFG_BITS-1:0] set_size;
		frt_req_t            req;
		logic                fixed;
		frt_rsp_t            want;
	} stim_row_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                req_valid   = 1'b0;
	logic                req_ready;
	frt_req_t            req         = '0;
	logic                rsp_valid;
	logic                rsp_ready   = 1'b0;
	frt_rsp_t            rsp;
	logic                cfg_we      = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata   = '0;

	// shadow of the tracker state
	logic [ID_BITS-1:0]   shadow_slots [CAPACITY];
	int                   shadow_oldest;
	int                   shadow_live;
	logic [TIME_BITS-1:0] shadow_clock;
	logic [CFG_BITS-1:0]  set_size_reg;

	frt_rsp_t  predicted_outcomes [$];
	stim_row_t directed_rows [$];
	int        mismatch_count = 0;
	int        items_sent     = 0;
	bit        steady_flow    = 1'b0;

	fifo_replacement_tracker_core #(
		.CAPACITY(CAPACITY),
		.ID_WIDTH(ID_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hit test, fifo eviction and saturating access clock
	function automatic frt_rsp_t track_request(input frt_req_t r);
		frt_rsp_t o;
		logic     found;
		o = '0;
		if (r.command == CMD_RESTART) begin
			shadow_live = (set_size_reg > CAPACITY) ? CAPACITY : int'(set_size_reg);
			for (int i = 0; i < shadow_live; i++)
				shadow_slots[i] = ID_BITS'(shadow_live - i);
			shadow_oldest = 0;
			shadow_clock  = '0;
			return o;
		end
		if (shadow_clock != TIME_MAX)
			shadow_clock = shadow_clock + 1'b1;
		found = 1'b0;
		for (int i = 0; i < shadow_live; i++)
			if (shadow_slots[i] == r.item_id)
				found = 1'b1;
		o.hit = found;
		if (!found && shadow_live != 0) begin
			o.evicted    = 1'b1;
			o.evicted_id = shadow_slots[shadow_oldest];
			shadow_slots[shadow_oldest] = r.item_id;
			shadow_oldest++;
			if (shadow_oldest >= shadow_live)
				shadow_oldest = 0;
		end
		o.event_time = shadow_clock;
		return o;
	endfunction

	// one request transfer, with random gaps ahead of it outside steady flow
	task automatic send_request(input frt_req_t r, input logic fixed, input frt_rsp_t want);
		frt_rsp_t predicted;
		while (!steady_flow && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = track_request(r);
		if (fixed)
			predicted = want;
		predicted_outcomes = {predicted_outcomes, predicted};
		items_sent++;
	endtask

	// register write once the pipeline has drained
	task automatic write_set_size(input logic [CFG_BITS-1:0] v);
		req_valid <= 1'b0;
		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		set_size_reg  = v;
	endtask

	// result side backpressure
	always @(posedge clk)
		rsp_ready <= steady_flow || ($urandom_range(99) >= 24);

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		frt_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (predicted_outcomes.size() == 0) begin
				$error("result transfer with nothing pending: %h", rsp);
				mismatch_count++;
			end else begin
				want = predicted_outcomes.pop_front();
				if (rsp.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, rsp.hit);
					mismatch_count++;
				end
				if (rsp.evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
					mismatch_count++;
				end
				if (rsp.evicted_id !== want.evicted_id) begin
					$error("evicted_id: expected %0d, got %0d", want.evicted_id,
						rsp.evicted_id);
					mismatch_count++;
				end
				if (rsp.event_time !== want.event_time) begin
					$error("event_time: expected %0d, got %0d", want.event_time,
						rsp.event_time);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		frt_req_t            r;
		logic [CFG_BITS-1:0] size;
		int                  phase_len;
		int                  span;
		int                  pick;

		set_size_reg  = CFG_RESET;
		shadow_live   = 0;
		shadow_oldest = 0;
		shadow_clock  = '0;
		foreach (shadow_slots[i])
			shadow_slots[i] = '0;

		// kind, size, command, id, check, hit, evicted, evicted_id, event_time
		directed_rows = '{
			// access before any restart: empty set, clock still runs
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0005, FIXED,   1'b0, 1'b0, 16'd0,   32'd1},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0000, FIXED,   1'b0, 1'b0, 16'd0,   32'd2},
			// restart ignores its id; reset size holds just id 1
			{ROW_ITEM, 8'd0,   CMD_RESTART, 16'hFFFF, FIXED,   1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0001, FIXED,   1'b1, 1'b0, 16'd0,   32'd1},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0007, FIXED,   1'b0, 1'b1, 16'd1,   32'd2},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0007, FIXED,   1'b1, 1'b0, 16'd0,   32'd3},
			// full capacity
			{ROW_CFG,  8'd128, CMD_ACCESS,  16'h0000, PREDICT, 1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_RESTART, 16'h0000, FIXED,   1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0080, FIXED,   1'b1, 1'b0, 16'd0,   32'd1},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'hFFFF, FIXED,   1'b0, 1'b1, 16'd128, 32'd2},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'hFFFF, FIXED,   1'b1, 1'b0, 16'd0,   32'd3},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0000, FIXED,   1'b0, 1'b1, 16'd127, 32'd4},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0001, FIXED,   1'b1, 1'b0, 16'd0,   32'd5},
			// zero size: every access misses, nothing evicted
			{ROW_CFG,  8'd0,   CMD_ACCESS,  16'h0000, PREDICT, 1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_RESTART, 16'h1234, FIXED,   1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0001, FIXED,   1'b0, 1'b0, 16'd0,   32'd1},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0000, FIXED,   1'b0, 1'b0, 16'd0,   32'd2},
			// size above capacity saturates
			{ROW_CFG,  8'd255, CMD_ACCESS,  16'h0000, PREDICT, 1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_RESTART, 16'h0000, FIXED,   1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0080, FIXED,   1'b1, 1'b0, 16'd0,   32'd1},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0081, FIXED,   1'b0, 1'b1, 16'd128, 32'd2},
			// new size without restart keeps the latched one
			{ROW_CFG,  8'd3,   CMD_ACCESS,  16'h0000, PREDICT, 1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'hAAAA, PREDICT, 1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_RESTART, 16'h0000, FIXED,   1'b0, 1'b0, 16'd0,   32'd0},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h0003, FIXED,   1'b1, 1'b0, 16'd0,   32'd1},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h5555, FIXED,   1'b0, 1'b1, 16'd3,   32'd2},
			{ROW_ITEM, 8'd0,   CMD_ACCESS,  16'h8000, PREDICT, 1'b0, 1'b0, 16'd0,   32'd0}
		};

		// reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_set_size(directed_rows[i].set_size);
			else
				send_request(directed_rows[i].req, directed_rows[i].fixed,
					directed_rows[i].want);
		end

		// random phases: new size, usually a restart, then a run of requests, mostly accesses
		while (items_sent < RAND_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 8)
				size = '0;
			else if (pick < 16)
				size = 8'd128;
			else if (pick < 22)
				size = 8'hFF;
			else if (pick < 40)
				size = CFG_BITS'($urandom_range(255));
			else
				size = CFG_BITS'($urandom_range(12, 1));
			write_set_size(size);
			if ($urandom_range(9) != 0) begin
				r.command = CMD_RESTART;
				r.item_id = ID_BITS'($urandom);
				send_request(r, PREDICT, '0);
			end
			span      = ((size > CAPACITY) ? CAPACITY : int'(size)) + 8;
			span      = span + $urandom_range(span);
			phase_len = $urandom_range(90, 20);
			repeat (phase_len) begin
				steady_flow = (items_sent >= 500 && items_sent < 700);
				pick = $urandom_range(99);
				if (pick < 5) begin
					r.command = CMD_RESTART;
					r.item_id = ID_BITS'($urandom);
				end else if (pick < 15) begin
					r.command = CMD_ACCESS;
					r.item_id = ID_BITS'($urandom);
				end else begin
					r.command = CMD_ACCESS;
					r.item_id = ID_BITS'($urandom_range(span));
				end
				send_request(r, PREDICT, '0);
			end
		end

		// drain
		req_valid <= 1'b0;
		steady_flow = 1'b0;
		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
